// File: src/srts_pkg.sv
// Package for the servo ramp and timeout sequencer.
// Holds field widths, codes, reset values and the sequencer state type.
// No dependencies.
package srts_pkg;

    localparam int DIA_COUNT      = 2;
    localparam int MAX_SLOTS      = 16;
    localparam int COLD_SLOTS_DEF = 8;

    localparam int FUNC_W     = 2;
    localparam int IDX_W      = 4;
    localparam int ANG_W      = 8;
    localparam int MS_W       = 16;
    localparam int ELAP_W     = 17;
    localparam int PROD_W     = 24;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLD_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA0       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA1       = 3'd6;

    localparam logic [ANG_W-1:0] RST_COLD_START = 8'd0;
    localparam logic [ANG_W-1:0] RST_COLD_END   = 8'd180;
    localparam logic [MS_W-1:0]  RST_MS         = 16'd1000;
    localparam logic [ANG_W-1:0] RST_D0_CLOSED  = 8'd100;
    localparam logic [ANG_W-1:0] RST_D0_OPEN    = 8'd145;
    localparam logic [ANG_W-1:0] RST_D1_CLOSED  = 8'd85;
    localparam logic [ANG_W-1:0] RST_D1_OPEN    = 8'd130;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_EJECT = 2'd1,
        FUNC_MOVE  = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_ALREADY = 2'd1,
        STAT_RESTART = 2'd2,
        STAT_BAD     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

endpackage

// File: src/srts_in_if.sv
// Command channel of the servo ramp and timeout sequencer.
// Valid/ready handshake with func, slot_index and target_open; uses srts_pkg.
interface srts_in_if;
    logic                          valid;
    logic                          ready;
    logic [srts_pkg::FUNC_W-1:0]   func;
    logic [srts_pkg::IDX_W-1:0]    slot_index;
    logic                          target_open;

    modport source(output valid, func, slot_index, target_open, input ready);
    modport sink(input valid, func, slot_index, target_open, output ready);
endinterface

// File: src/srts_out_if.sv
// Result channel of the servo ramp and timeout sequencer.
// Valid/ready handshake carrying servo angles, enables and status; uses srts_pkg.
interface srts_out_if;
    logic                          valid;
    logic                          ready;
    logic [srts_pkg::ANG_W-1:0]    cold_angle;
    logic [srts_pkg::ANG_W-1:0]    slot_enables;
    logic [srts_pkg::ANG_W-1:0]    d0_angle;
    logic                          d0_attached;
    logic                          d0_is_open;
    logic [srts_pkg::ANG_W-1:0]    d1_angle;
    logic                          d1_attached;
    logic                          d1_is_open;
    logic [srts_pkg::STAT_W-1:0]   cmd_status;

    modport source(output valid, cold_angle, slot_enables, d0_angle, d0_attached,
                   d0_is_open, d1_angle, d1_attached, d1_is_open, cmd_status,
                   input ready);
    modport sink(input valid, cold_angle, slot_enables, d0_angle, d0_attached,
                 d0_is_open, d1_angle, d1_attached, d1_is_open, cmd_status,
                 output ready);
endinterface

// File: src/servo_ramp_timeout_sequencer.sv
// Top level of the servo ramp and timeout sequencer.
// Depends on srts_pkg, srts_in_if and srts_out_if.
//
// One command is taken at a time; each yields exactly one result transaction.
// Ejects, moves and ticks with no diaphragm mid-ramp go from acceptance straight
// to the done state, which loads the result register once it is free. A tick with
// a diaphragm mid-ramp first runs, for each ramping diaphragm, one load, 8 shift-add
// multiply steps, 8 restoring divide steps and one write-back on the single
// bit-serial multiply/divide unit shared by both diaphragms.
// The result register lets the next command in while a result waits.
module servo_ramp_timeout_sequencer #(
    parameter int COLD_SLOTS = srts_pkg::COLD_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srts_in_if.sink                             i_cmd,
    srts_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [srts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srts_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int ND   = srts_pkg::DIA_COUNT;
    localparam int AW   = srts_pkg::ANG_W;
    localparam int MW   = srts_pkg::MS_W;
    localparam int PW   = srts_pkg::PROD_W;

    // configuration
    logic [AW-1:0] r_cfg_start;
    logic [AW-1:0] r_cfg_end;
    logic [MW-1:0] r_cfg_timeout;
    logic [MW-1:0] r_cfg_ramp;
    logic [MW-1:0] r_cfg_hold;
    logic [MW-1:0] r_cfg_dia [ND];

    // block state
    logic                          r_cold_active, n_cold_active;
    logic [srts_pkg::ELAP_W-1:0]   r_cold_elapsed, n_cold_elapsed;
    logic [AW-1:0]                 r_cold_angle, n_cold_angle;
    logic [COLD_SLOTS-1:0]         r_mask, n_mask;
    logic                          r_dia_open [ND];
    logic                          n_dia_open [ND];
    logic                          r_ramp_active [ND];
    logic                          n_ramp_active [ND];
    logic [MW-1:0]                 r_ramp_elapsed [ND];
    logic [MW-1:0]                 n_ramp_elapsed [ND];
    logic                          r_hold_active [ND];
    logic                          n_hold_active [ND];
    logic [MW-1:0]                 r_hold_elapsed [ND];
    logic [MW-1:0]                 n_hold_elapsed [ND];
    logic                          r_dia_attached [ND];
    logic                          n_dia_attached [ND];
    logic [AW-1:0]                 r_dia_angle [ND];
    logic [AW-1:0]                 n_dia_angle [ND];

    // sequencer and serial arithmetic
    srts_pkg::t_state              r_state, n_state;
    srts_pkg::t_status             r_status, n_status;
    logic                          r_dsel, n_dsel;
    logic [ND-1:0]                 r_need, n_need;
    logic [PW-1:0]                 r_mcand, n_mcand;
    logic [AW-1:0]                 r_mplier, n_mplier;
    logic [PW-1:0]                 r_prod, n_prod;
    logic                          r_neg, n_neg;
    logic [MW-1:0]                 r_rem, n_rem;
    logic [AW-1:0]                 r_quo, n_quo;
    logic [2:0]                    r_cnt, n_cnt;

    // result register
    logic                          r_out_valid, n_out_valid;
    logic [AW-1:0]                 r_out_cold, n_out_cold;
    logic [AW-1:0]                 r_out_en, n_out_en;
    logic [AW-1:0]                 r_out_a0, n_out_a0;
    logic                          r_out_at0, n_out_at0;
    logic                          r_out_op0, n_out_op0;
    logic [AW-1:0]                 r_out_a1, n_out_a1;
    logic                          r_out_at1, n_out_at1;
    logic                          r_out_op1, n_out_op1;
    logic [srts_pkg::STAT_W-1:0]   r_out_stat, n_out_stat;

    // combinational helpers
    logic [AW-1:0]                 w_from [ND];
    logic [AW-1:0]                 w_to [ND];
    logic [AW-1:0]                 w_from_sel;
    logic [AW-1:0]                 w_to_sel;
    logic                          w_neg_sel;
    logic [AW-1:0]                 w_span_abs;
    logic [PW-1:0]                 w_prod_add;
    logic [MW:0]                   w_trial;
    logic [MW:0]                   w_diff;
    logic                          w_ge;
    logic                          w_accept;
    logic [srts_pkg::MAX_SLOTS-1:0] w_slot_bit;
    logic [srts_pkg::MAX_SLOTS-1:0] w_mask_ext;
    logic                          w_slot_ok;
    logic                          w_dia_bad;
    logic                          w_didx;

    for (genvar g = 0; g < ND; g++) begin : g_ends
        assign w_from[g] = r_dia_open[g] ? r_cfg_dia[g][2*AW-1:AW] : r_cfg_dia[g][AW-1:0];
        assign w_to[g]   = r_dia_open[g] ? r_cfg_dia[g][AW-1:0] : r_cfg_dia[g][2*AW-1:AW];
    end

    assign w_from_sel = w_from[r_dsel];
    assign w_to_sel   = w_to[r_dsel];
    assign w_neg_sel  = w_to_sel < w_from_sel;
    assign w_span_abs = w_neg_sel ? (w_from_sel - w_to_sel) : (w_to_sel - w_from_sel);
    assign w_prod_add = r_prod + (r_mplier[0] ? r_mcand : '0);
    assign w_trial    = {r_rem, r_prod[AW-1]};
    assign w_diff     = w_trial - {1'b0, r_cfg_ramp};
    assign w_ge       = w_trial >= {1'b0, r_cfg_ramp};

    assign w_accept   = i_cmd.valid && (r_state == srts_pkg::S_IDLE);
    assign w_slot_bit = srts_pkg::MAX_SLOTS'(1) << i_cmd.slot_index;
    assign w_mask_ext = (srts_pkg::MAX_SLOTS)'(r_mask);
    assign w_slot_ok  = {1'b0, i_cmd.slot_index} < 5'(COLD_SLOTS);
    assign w_dia_bad  = i_cmd.slot_index >= srts_pkg::IDX_W'(ND);
    assign w_didx     = i_cmd.slot_index[0];

    assign i_cmd.ready        = (r_state == srts_pkg::S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.cold_angle   = r_out_cold;
    assign o_res.slot_enables = r_out_en;
    assign o_res.d0_angle     = r_out_a0;
    assign o_res.d0_attached  = r_out_at0;
    assign o_res.d0_is_open   = r_out_op0;
    assign o_res.d1_angle     = r_out_a1;
    assign o_res.d1_attached  = r_out_at1;
    assign o_res.d1_is_open   = r_out_op1;
    assign o_res.cmd_status   = r_out_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start   <= srts_pkg::RST_COLD_START;
            r_cfg_end     <= srts_pkg::RST_COLD_END;
            r_cfg_timeout <= srts_pkg::RST_MS;
            r_cfg_ramp    <= srts_pkg::RST_MS;
            r_cfg_hold    <= srts_pkg::RST_MS;
            r_cfg_dia[0]  <= {srts_pkg::RST_D0_OPEN, srts_pkg::RST_D0_CLOSED};
            r_cfg_dia[1]  <= {srts_pkg::RST_D1_OPEN, srts_pkg::RST_D1_CLOSED};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srts_pkg::CFG_COLD_START: r_cfg_start   <= i_cfg_wdata[AW-1:0];
                srts_pkg::CFG_COLD_END:   r_cfg_end     <= i_cfg_wdata[AW-1:0];
                srts_pkg::CFG_TIMEOUT:    r_cfg_timeout <= i_cfg_wdata;
                srts_pkg::CFG_RAMP:       r_cfg_ramp    <= i_cfg_wdata;
                srts_pkg::CFG_HOLD:       r_cfg_hold    <= i_cfg_wdata;
                srts_pkg::CFG_DIA0:       r_cfg_dia[0]  <= i_cfg_wdata;
                srts_pkg::CFG_DIA1:       r_cfg_dia[1]  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= srts_pkg::S_IDLE;
            r_out_valid    <= 1'b0;
            r_need         <= '0;
            r_cold_active  <= 1'b0;
            r_cold_elapsed <= '0;
            r_cold_angle   <= srts_pkg::RST_COLD_START;
            r_mask         <= '0;
            for (int d = 0; d < ND; d++) begin
                r_dia_open[d]     <= 1'b0;
                r_ramp_active[d]  <= 1'b0;
                r_ramp_elapsed[d] <= '0;
                r_hold_active[d]  <= 1'b1;
                r_hold_elapsed[d] <= '0;
                r_dia_attached[d] <= 1'b1;
            end
            r_dia_angle[0] <= srts_pkg::RST_D0_CLOSED;
            r_dia_angle[1] <= srts_pkg::RST_D1_CLOSED;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_need         <= n_need;
            r_cold_active  <= n_cold_active;
            r_cold_elapsed <= n_cold_elapsed;
            r_cold_angle   <= n_cold_angle;
            r_mask         <= n_mask;
            for (int d = 0; d < ND; d++) begin
                r_dia_open[d]     <= n_dia_open[d];
                r_ramp_active[d]  <= n_ramp_active[d];
                r_ramp_elapsed[d] <= n_ramp_elapsed[d];
                r_hold_active[d]  <= n_hold_active[d];
                r_hold_elapsed[d] <= n_hold_elapsed[d];
                r_dia_attached[d] <= n_dia_attached[d];
                r_dia_angle[d]    <= n_dia_angle[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_dsel     <= n_dsel;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_cold <= n_out_cold;
        r_out_en   <= n_out_en;
        r_out_a0   <= n_out_a0;
        r_out_at0  <= n_out_at0;
        r_out_op0  <= n_out_op0;
        r_out_a1   <= n_out_a1;
        r_out_at1  <= n_out_at1;
        r_out_op1  <= n_out_op1;
        r_out_stat <= n_out_stat;
    end

    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        n_dsel         = r_dsel;
        n_need         = r_need;
        n_mcand        = r_mcand;
        n_mplier       = r_mplier;
        n_prod         = r_prod;
        n_neg          = r_neg;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_cnt          = r_cnt;
        n_cold_active  = r_cold_active;
        n_cold_elapsed = r_cold_elapsed;
        n_cold_angle   = r_cold_angle;
        n_mask         = r_mask;
        n_dia_open     = r_dia_open;
        n_ramp_active  = r_ramp_active;
        n_ramp_elapsed = r_ramp_elapsed;
        n_hold_active  = r_hold_active;
        n_hold_elapsed = r_hold_elapsed;
        n_dia_attached = r_dia_attached;
        n_dia_angle    = r_dia_angle;
        n_out_valid    = r_out_valid;
        n_out_cold     = r_out_cold;
        n_out_en       = r_out_en;
        n_out_a0       = r_out_a0;
        n_out_at0      = r_out_at0;
        n_out_op0      = r_out_op0;
        n_out_a1       = r_out_a1;
        n_out_at1      = r_out_at1;
        n_out_op1      = r_out_op1;
        n_out_stat     = r_out_stat;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            srts_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_status = srts_pkg::STAT_OK;
                    n_need   = '0;
                    unique case (srts_pkg::t_func'(i_cmd.func))
                        srts_pkg::FUNC_TICK: begin
                            if (r_cold_active) begin
                                n_cold_elapsed = (r_cold_elapsed == '1) ? r_cold_elapsed
                                                                        : r_cold_elapsed + 1'b1;
                                if (n_cold_elapsed > {1'b0, r_cfg_timeout}) begin
                                    n_cold_angle = r_cfg_start;
                                    if (n_cold_elapsed > {r_cfg_timeout, 1'b0}) begin
                                        n_mask        = '0;
                                        n_cold_active = 1'b0;
                                    end
                                end
                            end
                            for (int d = 0; d < ND; d++) begin
                                if (r_ramp_active[d]) begin
                                    n_ramp_elapsed[d] = (r_ramp_elapsed[d] == '1)
                                                        ? r_ramp_elapsed[d]
                                                        : r_ramp_elapsed[d] + 1'b1;
                                    if (n_ramp_elapsed[d] < r_cfg_ramp) begin
                                        n_need[d] = 1'b1;
                                    end else begin
                                        n_dia_angle[d]    = w_to[d];
                                        n_hold_active[d]  = 1'b1;
                                        n_hold_elapsed[d] = '0;
                                        n_dia_open[d]     = !r_dia_open[d];
                                        n_ramp_active[d]  = 1'b0;
                                    end
                                end else if (r_hold_active[d]) begin
                                    n_hold_elapsed[d] = (r_hold_elapsed[d] == '1)
                                                        ? r_hold_elapsed[d]
                                                        : r_hold_elapsed[d] + 1'b1;
                                    if (n_hold_elapsed[d] > r_cfg_hold) begin
                                        n_dia_attached[d] = 1'b0;
                                        n_hold_active[d]  = 1'b0;
                                    end
                                end
                            end
                        end
                        srts_pkg::FUNC_EJECT: begin
                            if (w_slot_ok) begin
                                n_cold_active  = 1'b1;
                                n_cold_elapsed = '0;
                                n_mask         = r_mask | w_slot_bit[COLD_SLOTS-1:0];
                                n_cold_angle   = r_cfg_end;
                            end else begin
                                n_status = srts_pkg::STAT_BAD;
                            end
                        end
                        srts_pkg::FUNC_MOVE: begin
                            if (w_dia_bad) begin
                                n_status = srts_pkg::STAT_BAD;
                            end else if (r_dia_open[w_didx] == i_cmd.target_open) begin
                                n_status = srts_pkg::STAT_ALREADY;
                            end else begin
                                n_status = r_ramp_active[w_didx] ? srts_pkg::STAT_RESTART
                                                                 : srts_pkg::STAT_OK;
                                n_ramp_active[w_didx]  = 1'b1;
                                n_ramp_elapsed[w_didx] = '0;
                                n_dia_attached[w_didx] = 1'b1;
                            end
                        end
                        default: begin
                            n_status = srts_pkg::STAT_BAD;
                        end
                    endcase
                    n_dsel  = !n_need[0];
                    n_state = (|n_need) ? srts_pkg::S_LOAD : srts_pkg::S_DONE;
                end
            end
            srts_pkg::S_LOAD: begin
                n_mcand  = PW'(r_ramp_elapsed[r_dsel]);
                n_mplier = w_span_abs;
                n_neg    = w_neg_sel;
                n_prod   = '0;
                n_cnt    = '0;
                n_state  = srts_pkg::S_MUL;
            end
            srts_pkg::S_MUL: begin
                n_prod   = w_prod_add;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_rem   = w_prod_add[PW-1:AW];
                    n_state = srts_pkg::S_DIV;
                end
            end
            srts_pkg::S_DIV: begin
                n_rem  = w_ge ? w_diff[MW-1:0] : w_trial[MW-1:0];
                n_quo  = {r_quo[AW-2:0], w_ge};
                n_prod = r_prod << 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = srts_pkg::S_WB;
                end
            end
            srts_pkg::S_WB: begin
                n_dia_angle[r_dsel] = r_neg ? (w_from_sel - r_quo) : (w_from_sel + r_quo);
                n_need[r_dsel]      = 1'b0;
                if (!r_dsel && r_need[1]) begin
                    n_dsel  = 1'b1;
                    n_state = srts_pkg::S_LOAD;
                end else begin
                    n_state = srts_pkg::S_DONE;
                end
            end
            srts_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cold  = r_cold_angle;
                    n_out_en    = w_mask_ext[AW-1:0];
                    n_out_a0    = r_dia_angle[0];
                    n_out_at0   = r_dia_attached[0];
                    n_out_op0   = r_dia_open[0];
                    n_out_a1    = r_dia_angle[1];
                    n_out_at1   = r_dia_attached[1];
                    n_out_op1   = r_dia_open[1];
                    n_out_stat  = r_status;
                    n_state     = srts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srts_pkg::S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != srts_pkg::S_IDLE))
        else $error("sequencer idle after a command transaction");

    a_mask_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cold_active |-> (r_mask == '0))
        else $error("enable lines held with dispenser timer stopped");

    a_ramp0_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp_active[0] |-> r_dia_attached[0])
        else $error("diaphragm 0 ramping while detached");

    a_ramp1_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp_active[1] |-> r_dia_attached[1])
        else $error("diaphragm 1 ramping while detached");

endmodule
